/* rtl/cyk_pkg.sv */
// cyk_pkg: shared constants, operation codes and types of the cyk recogniser
// no dependencies; imported by the interfaces and by every module of the block
`default_nettype none

package cyk_pkg;

   // grammar and word limits
   localparam int MAX_NONTERMS = 16;
   localparam int MAX_LEN      = 32;

   // derived widths
   localparam int NT_W       = $clog2(MAX_NONTERMS);
   localparam int IW         = $clog2(MAX_LEN);
   localparam int LEN_CW     = $clog2(MAX_LEN + 1);
   localparam int ROW_W      = MAX_NONTERMS * MAX_NONTERMS;
   localparam int ROW_BW     = $clog2(ROW_W);
   localparam int TERM_DEPTH = 256;
   localparam int SYM_W      = 8;
   localparam int CHART_AW   = 2 * IW;

   // configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;
   localparam logic CSR_IDX_START = 1'b0;

   // operation codes
   localparam logic [2:0] OP_ADD_TERM  = 3'd0;
   localparam logic [2:0] OP_ADD_PAIR  = 3'd1;
   localparam logic [2:0] OP_CLEAR     = 3'd2;
   localparam logic [2:0] OP_WORD_BYTE = 3'd3;
   localparam logic [2:0] OP_END_WORD  = 3'd4;

   typedef logic [MAX_NONTERMS-1:0] nt_mask_type;
   typedef logic [ROW_W-1:0]        pair_row_type;

   // requests from the sequencer to the rule store
   typedef struct packed {
      logic         clear;
      logic         term_rd;
      logic         term_wr;
      logic [SYM_W-1:0] term_addr;
      nt_mask_type  term_wdata;
      logic         pair_rd;
      logic         pair_wr;
      logic [NT_W-1:0] pair_row;
      pair_row_type pair_wdata;
   } rule_req_type;

endpackage

`default_nettype wire

/* rtl/cyk_if.sv */
// cyk_if: valid/ready channel interfaces for item and result transfers
// depends on cyk_pkg
`default_nettype none

interface cyk_req_if
   import cyk_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [2:0]       operation;
   logic [3:0]       head;
   logic [3:0]       left_part;
   logic [3:0]       right_part;
   logic [SYM_W-1:0] symbol;

   modport source (output valid, operation, head, left_part, right_part, symbol,
                   input ready);
   modport sink   (input valid, operation, head, left_part, right_part, symbol,
                   output ready);
endinterface

interface cyk_rsp_if
   import cyk_pkg::*;
   ();
   logic valid;
   logic ready;
   logic accepted;
   logic overflow;

   modport source (output valid, accepted, overflow, input ready);
   modport sink   (input valid, accepted, overflow, output ready);
endinterface

`default_nettype wire

/* rtl/cyk_cnf_recognizer.sv */
// Recogniser for a grammar in Chomsky normal form (CYK). Clear, word-byte and
// unused-code items are handled in the idle state; adding a terminal or pair
// rule is a read-modify-write of the rule memory. End of word with a too long
// or empty word also answers from the idle state. Otherwise the chart is filled
// by a sequencer: for each byte of the diagonal the byte is read, its terminal
// row read and the cell written; then for every split point of every span two
// cell reads, one load and the step to the next split, a check of each left
// nonterminal and, for each nonterminal present in the left cell, a pair-rule
// row read and accumulate through the single shared combine unit; finally the
// answer is read. Input is held off for the whole evaluation. Rule memories
// need no clearing pass: reset and the clear operation act at once through
// valid bits.
// depends on cyk_pkg, cyk_if, cyk_rule_store, cyk_comb_unit
`default_nettype none

module cyk_cnf_recognizer
   import cyk_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   cyk_req_if.sink                req_if,
   cyk_rsp_if.source              rsp_if,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output      logic [CSR_DW-1:0] csr_prdata,
   output      logic              csr_pready
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_TERM_WR, ST_PAIR_WR, ST_DIAG_WORD, ST_DIAG_TERM, ST_DIAG_WR,
      ST_SPLIT_L, ST_SPLIT_R, ST_SPLIT_C, ST_COMB_RD, ST_COMB_ACC, ST_SPLIT_NEXT,
      ST_FIN_RD, ST_FIN
   } state_type;

   state_type          state_ff, state_in;
   logic [LEN_CW-1:0]  word_len_ff, word_len_in;
   logic               too_long_ff, too_long_in;
   logic [LEN_CW-1:0]  n_ff, n_in;
   logic [LEN_CW-1:0]  len_ff, len_in;
   logic [IW-1:0]      i_ff, i_in;
   logic [IW-1:0]      k_ff, k_in;
   logic [NT_W-1:0]    b_ff, b_in;
   nt_mask_type        lm_ff, lm_in;
   nt_mask_type        rm_ff, rm_in;
   logic [3:0]         head_ff, head_in;
   logic [3:0]         lp_ff, lp_in;
   logic [3:0]         rp_ff, rp_in;
   logic [SYM_W-1:0]   sym_ff, sym_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               accepted_ff, accepted_in;
   logic               overflow_ff, overflow_in;
   logic [3:0]         start_ff;

   rule_req_type       rq;
   nt_mask_type        term_rdata;
   pair_row_type       pair_rdata;
   nt_mask_type        acc;
   logic               acc_clear;
   logic               acc_step;

   // chart and word buffer memories
   nt_mask_type        chart_mem [2**CHART_AW];
   nt_mask_type        chart_rd_ff;
   logic               chart_we;
   logic               chart_re;
   logic [CHART_AW-1:0] chart_waddr;
   logic [CHART_AW-1:0] chart_raddr;
   nt_mask_type        chart_wdata;
   logic [SYM_W-1:0]   word_mem [MAX_LEN];
   logic [SYM_W-1:0]   word_rd_ff;
   logic               word_we;
   logic               word_re;

   logic               ready_w;
   logic               req_xfer;
   logic [LEN_CW-1:0]  j_w;
   logic [IW-1:0]      j_idx;
   logic [LEN_CW-1:0]  n_m1;
   logic               b_last;
   logic               start_ok;
   nt_mask_type        fin_sh;
   logic [ROW_BW-1:0]  pair_bit;

   cyk_rule_store u_rules (
      .clock      (clock),
      .reset      (reset),
      .rq         (rq),
      .term_rdata (term_rdata),
      .pair_rdata (pair_rdata)
   );

   cyk_comb_unit u_comb (
      .clock (clock),
      .clear (acc_clear),
      .step  (acc_step),
      .rm    (rm_ff),
      .row   (pair_rdata),
      .heads (acc)
   );

   // handshake
   assign ready_w       = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign req_xfer      = req_if.valid && ready_w;
   assign req_if.ready  = ready_w;
   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.accepted = accepted_ff;
   assign rsp_if.overflow = overflow_ff;

   // span bookkeeping
   assign j_w      = LEN_CW'(i_ff) + len_ff - LEN_CW'(1);
   assign j_idx    = j_w[IW-1:0];
   assign n_m1     = n_ff - LEN_CW'(1);
   assign b_last   = (b_ff == NT_W'(MAX_NONTERMS - 1));
   assign start_ok = (int'(start_ff) < MAX_NONTERMS);
   assign fin_sh   = chart_rd_ff >> start_ff;
   assign pair_bit = ROW_BW'(int'(rp_ff) * MAX_NONTERMS + int'(head_ff));

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      word_len_in  = word_len_ff;
      too_long_in  = too_long_ff;
      n_in         = n_ff;
      len_in       = len_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      b_in         = b_ff;
      lm_in        = lm_ff;
      rm_in        = rm_ff;
      head_in      = head_ff;
      lp_in        = lp_ff;
      rp_in        = rp_ff;
      sym_in       = sym_ff;
      rsp_valid_in = rsp_valid_ff;
      accepted_in  = accepted_ff;
      overflow_in  = overflow_ff;
      rq           = '0;
      acc_clear    = 1'b0;
      acc_step     = 1'b0;
      chart_we     = 1'b0;
      chart_re     = 1'b0;
      chart_waddr  = {i_ff, j_idx};
      chart_raddr  = {i_ff, k_ff};
      chart_wdata  = acc;
      word_we      = 1'b0;
      word_re      = 1'b0;

      // result drained
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               head_in = req_if.head;
               lp_in   = req_if.left_part;
               rp_in   = req_if.right_part;
               sym_in  = req_if.symbol;
               case (req_if.operation)
                  OP_ADD_TERM: begin
                     if (int'(req_if.head) < MAX_NONTERMS) begin
                        rq.term_rd   = 1'b1;
                        rq.term_addr = req_if.symbol;
                        state_in     = ST_TERM_WR;
                     end
                  end
                  OP_ADD_PAIR: begin
                     if (int'(req_if.head) < MAX_NONTERMS &&
                         int'(req_if.left_part) < MAX_NONTERMS &&
                         int'(req_if.right_part) < MAX_NONTERMS) begin
                        rq.pair_rd  = 1'b1;
                        rq.pair_row = NT_W'(req_if.left_part);
                        state_in    = ST_PAIR_WR;
                     end
                  end
                  OP_CLEAR: begin
                     rq.clear = 1'b1;
                  end
                  OP_WORD_BYTE: begin
                     if (int'(word_len_ff) < MAX_LEN) begin
                        word_we     = 1'b1;
                        word_len_in = word_len_ff + LEN_CW'(1);
                     end else begin
                        too_long_in = 1'b1;
                     end
                  end
                  OP_END_WORD: begin
                     word_len_in = '0;
                     too_long_in = 1'b0;
                     if (too_long_ff) begin
                        rsp_valid_in = 1'b1;
                        accepted_in  = 1'b0;
                        overflow_in  = 1'b1;
                     end else if (word_len_ff == '0) begin
                        rsp_valid_in = 1'b1;
                        accepted_in  = 1'b1;
                        overflow_in  = 1'b0;
                     end else begin
                        n_in     = word_len_ff;
                        i_in     = '0;
                        state_in = ST_DIAG_WORD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // rule updates: read-modify-write
         ST_TERM_WR: begin
            rq.term_wr    = 1'b1;
            rq.term_addr  = sym_ff;
            rq.term_wdata = term_rdata | (nt_mask_type'(1) << head_ff);
            state_in      = ST_IDLE;
         end
         ST_PAIR_WR: begin
            rq.pair_wr    = 1'b1;
            rq.pair_row   = NT_W'(lp_ff);
            rq.pair_wdata = pair_rdata | (pair_row_type'(1) << pair_bit);
            state_in      = ST_IDLE;
         end

         // diagonal of the chart from the terminal rules
         ST_DIAG_WORD: begin
            word_re  = 1'b1;
            state_in = ST_DIAG_TERM;
         end
         ST_DIAG_TERM: begin
            rq.term_rd   = 1'b1;
            rq.term_addr = word_rd_ff;
            state_in     = ST_DIAG_WR;
         end
         ST_DIAG_WR: begin
            chart_we    = 1'b1;
            chart_waddr = {i_ff, i_ff};
            chart_wdata = term_rdata;
            if (LEN_CW'(i_ff) + LEN_CW'(1) < n_ff) begin
               i_in     = i_ff + IW'(1);
               state_in = ST_DIAG_WORD;
            end else if (n_ff == LEN_CW'(1)) begin
               state_in = ST_FIN_RD;
            end else begin
               len_in   = LEN_CW'(2);
               i_in     = '0;
               k_in     = '0;
               state_in = ST_SPLIT_L;
            end
         end

         // one split point: fetch both cells
         ST_SPLIT_L: begin
            if (k_ff == i_ff) begin
               acc_clear = 1'b1;
            end
            chart_re    = 1'b1;
            chart_raddr = {i_ff, k_ff};
            state_in    = ST_SPLIT_R;
         end
         ST_SPLIT_R: begin
            lm_in       = chart_rd_ff;
            chart_re    = 1'b1;
            chart_raddr = {k_ff + IW'(1), j_idx};
            state_in    = ST_SPLIT_C;
         end
         ST_SPLIT_C: begin
            rm_in    = chart_rd_ff;
            b_in     = '0;
            state_in = ST_COMB_RD;
         end

         // walk left nonterminals, skipping absent ones
         ST_COMB_RD: begin
            if (lm_ff[b_ff]) begin
               rq.pair_rd  = 1'b1;
               rq.pair_row = b_ff;
               state_in    = ST_COMB_ACC;
            end else if (b_last) begin
               state_in = ST_SPLIT_NEXT;
            end else begin
               b_in = b_ff + NT_W'(1);
            end
         end
         ST_COMB_ACC: begin
            acc_step = 1'b1;
            if (b_last) begin
               state_in = ST_SPLIT_NEXT;
            end else begin
               b_in     = b_ff + NT_W'(1);
               state_in = ST_COMB_RD;
            end
         end

         // next split, next span or next span length
         ST_SPLIT_NEXT: begin
            if (LEN_CW'(k_ff) + LEN_CW'(1) < j_w) begin
               k_in     = k_ff + IW'(1);
               state_in = ST_SPLIT_L;
            end else begin
               chart_we = 1'b1;
               if ((LEN_CW+1)'(i_ff) + (LEN_CW+1)'(len_ff) < (LEN_CW+1)'(n_ff)) begin
                  i_in     = i_ff + IW'(1);
                  k_in     = i_ff + IW'(1);
                  state_in = ST_SPLIT_L;
               end else if (len_ff < n_ff) begin
                  len_in   = len_ff + LEN_CW'(1);
                  i_in     = '0;
                  k_in     = '0;
                  state_in = ST_SPLIT_L;
               end else begin
                  state_in = ST_FIN_RD;
               end
            end
         end

         // whole-word cell decides
         ST_FIN_RD: begin
            chart_re    = 1'b1;
            chart_raddr = {IW'(0), n_m1[IW-1:0]};
            state_in    = ST_FIN;
         end
         ST_FIN: begin
            rsp_valid_in = 1'b1;
            accepted_in  = start_ok && fin_sh[0];
            overflow_in  = 1'b0;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      len_ff      <= len_in;
      i_ff        <= i_in;
      k_ff        <= k_in;
      b_ff        <= b_in;
      lm_ff       <= lm_in;
      rm_ff       <= rm_in;
      head_ff     <= head_in;
      lp_ff       <= lp_in;
      rp_ff       <= rp_in;
      sym_ff      <= sym_in;
      accepted_ff <= accepted_in;
      overflow_ff <= overflow_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         word_len_ff  <= '0;
         too_long_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_len_ff  <= word_len_in;
         too_long_ff  <= too_long_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // chart memory
   always_ff @(posedge clock) begin
      if (chart_we) begin
         chart_mem[chart_waddr] <= chart_wdata;
      end
      if (chart_re) begin
         chart_rd_ff <= chart_mem[chart_raddr];
      end
   end

   // word buffer
   always_ff @(posedge clock) begin
      if (word_we) begin
         word_mem[word_len_ff[IW-1:0]] <= req_if.symbol;
      end
      if (word_re) begin
         word_rd_ff <= word_mem[i_ff];
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[2] == CSR_IDX_START) begin
         start_ff <= csr_pwdata[3:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_START) ? CSR_DW'(start_ff) : '0;

   // checks
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(accepted_ff && overflow_ff))
      else $error("accepted and overflow both set");

   a_end_clears_word: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_if.operation == OP_END_WORD) |=>
         (word_len_ff == '0 && !too_long_ff))
      else $error("word state not cleared by end of word");

   a_split_in_span: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SPLIT_L) |-> (LEN_CW'(k_ff) < j_w && k_ff >= i_ff))
      else $error("split point outside span");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      int'(word_len_ff) <= MAX_LEN)
      else $error("word length past limit");

endmodule

`default_nettype wire

/* rtl/cyk_rule_store.sv */
// cyk_rule_store: terminal-rule and pair-rule memories with per-entry valid bits
// depends on cyk_pkg; read data registered, invalid entries read as zero
`default_nettype none

module cyk_rule_store
   import cyk_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire rule_req_type rq,
   output      nt_mask_type  term_rdata,
   output      pair_row_type pair_rdata
);

   nt_mask_type               term_mem [TERM_DEPTH];
   logic [TERM_DEPTH-1:0]     term_vld_ff;
   nt_mask_type               term_rd_ff;
   logic                      term_rv_ff;

   pair_row_type              pair_mem [MAX_NONTERMS];
   logic [MAX_NONTERMS-1:0]   pair_vld_ff;
   pair_row_type              pair_rd_ff;
   logic                      pair_rv_ff;

   // valid bits, cleared at reset and by a clear transfer
   always_ff @(posedge clock) begin
      if (reset || rq.clear) begin
         term_vld_ff <= '0;
         pair_vld_ff <= '0;
      end else begin
         if (rq.term_wr) begin
            term_vld_ff[rq.term_addr] <= 1'b1;
         end
         if (rq.pair_wr) begin
            pair_vld_ff[rq.pair_row] <= 1'b1;
         end
      end
   end

   // memory writes
   always_ff @(posedge clock) begin
      if (rq.term_wr) begin
         term_mem[rq.term_addr] <= rq.term_wdata;
      end
      if (rq.pair_wr) begin
         pair_mem[rq.pair_row] <= rq.pair_wdata;
      end
   end

   // registered reads
   always_ff @(posedge clock) begin
      if (rq.term_rd) begin
         term_rd_ff <= term_mem[rq.term_addr];
         term_rv_ff <= term_vld_ff[rq.term_addr];
      end
      if (rq.pair_rd) begin
         pair_rd_ff <= pair_mem[rq.pair_row];
         pair_rv_ff <= pair_vld_ff[rq.pair_row];
      end
   end

   assign term_rdata = term_rv_ff ? term_rd_ff : '0;
   assign pair_rdata = pair_rv_ff ? pair_rd_ff : '0;

endmodule

`default_nettype wire

/* rtl/cyk_comb_unit.sv */
// cyk_comb_unit: shared head accumulator, one left nonterminal row per step
// depends on cyk_pkg
`default_nettype none

module cyk_comb_unit
   import cyk_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         clear,
   input  wire logic         step,
   input  wire nt_mask_type  rm,
   input  wire pair_row_type row,
   output      nt_mask_type  heads
);

   nt_mask_type acc_ff;
   nt_mask_type gated;

   // heads of all pairs (b, c) with c in the right mask
   always_comb begin
      gated = '0;
      for (int c = 0; c < MAX_NONTERMS; c++) begin
         if (rm[c]) begin
            gated = gated | row[c*MAX_NONTERMS +: MAX_NONTERMS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clear) begin
         acc_ff <= '0;
      end else if (step) begin
         acc_ff <= acc_ff | gated;
      end
   end

   assign heads = acc_ff;

endmodule

`default_nettype wire
